[rtl/chs_pkg.sv]
// Package for the chained hash set: operation and status codes, controller
// states and default sizes. No dependencies.
`default_nettype none

package chs_pkg;

  localparam int unsigned NumBucketsDef  = 64;
  localparam int unsigned PoolEntriesDef = 128;
  localparam int unsigned KeyW           = 64;
  localparam int unsigned DivW           = 32;
  localparam int unsigned CountOutW      = 8;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_ZERO = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_DIV,
    S_ADD_RD,
    S_ADD_WR,
    S_HEAD_RD,
    S_HEAD_LD,
    S_NODE_RD,
    S_NODE_CHK,
    S_FIX,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/chs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module chs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/chained_hash_set.sv]
// Chained hash set of 64-bit keys with a free-list node pool.
// Depends on chs_pkg and chs_ram.
//
// Usage: one operation enters as a transfer on the input channel (mode_i,
// key_i) and leaves as exactly one transfer on the output channel (found_o,
// status_o, entry_count_o); one operation is in flight at a time. in_ready_o
// is high while the controller is idle. A finished result sits in the output
// register, so the next operation may be taken while the receiver stalls; it
// then waits in S_DONE until that register frees up.
//
// A zero key goes straight to the result with STATUS_ZERO. Otherwise a
// bit-serial divider finds the bucket, then add pushes a pool node onto the
// chain, lookup walks the chain to the first match, and delete walks the
// whole chain, freeing every match and patching the link of any removed
// node that has a predecessor. Clear is a sweep of one bucket head and one
// link a cycle.
// Reset runs the same sweep and holds in_ready_o low until it ends. Write
// the divisor (key_divisor_we_i) only while no operation is in flight; a
// zero acts as one.
`default_nettype none

module chained_hash_set
  import chs_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS  = NumBucketsDef,
  parameter int unsigned POOL_ENTRIES = PoolEntriesDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 key_divisor_we_i,
  input  wire logic [DivW-1:0]      key_divisor_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           mode_i,
  input  wire logic [KeyW-1:0]      key_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      found_o,
  output logic [1:0]                status_o,
  output logic [CountOutW-1:0]      entry_count_o
);

  // Link width holds every node index plus the end-of-chain value.
  localparam int unsigned LW    = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned PAW   = $clog2(POOL_ENTRIES);
  localparam int unsigned BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned CW    = (LW > CountOutW) ? LW : CountOutW;
  localparam int unsigned SWEEP = (NUM_BUCKETS > POOL_ENTRIES) ? NUM_BUCKETS
                                                               : POOL_ENTRIES;
  localparam int unsigned SW    = (SWEEP > 1) ? $clog2(SWEEP) : 1;
  localparam int unsigned DCW   = $clog2(KeyW);
  localparam logic [LW-1:0] LinkNone = LW'(POOL_ENTRIES);

  state_e state_q, state_d;

  logic [DivW-1:0]   divisor_q;
  logic [1:0]        mode_q;
  logic [KeyW-1:0]   key_q;
  logic [KeyW-1:0]   shift_q, shift_d;
  logic [DivW-1:0]   rem_q, rem_d;
  logic [BW-1:0]     bucket_q, bucket_d;
  logic [DCW-1:0]    div_cnt_q, div_cnt_d;
  logic [SW-1:0]     sweep_q, sweep_d;
  logic [LW-1:0]     free_head_q, free_head_d;
  logic [LW-1:0]     cur_q, cur_d;
  logic [LW-1:0]     prev_q, prev_d;
  logic [CW-1:0]     count_q, count_d;
  logic              found_q, found_d;
  logic [1:0]        status_q, status_d;
  logic              out_valid_q, out_valid_d;
  logic              res_found_q;
  logic [1:0]        res_status_q;
  logic [CountOutW-1:0] res_count_q;

  logic              in_xfer, out_free, sweep_last, div_last;
  logic              match;
  logic [DivW-1:0]   div_eff;
  logic [DivW:0]     trial;
  logic              qbit;
  logic [BW:0]       mod_t;

  // Memory ports.
  logic            head_we;
  logic [BW-1:0]   head_waddr, head_raddr;
  logic [LW-1:0]   head_wdata, head_rdata;
  logic            link_we;
  logic [PAW-1:0]  link_waddr, link_raddr;
  logic [LW-1:0]   link_wdata, link_rdata;
  logic            keys_we;
  logic [KeyW-1:0] keys_rdata;

  chs_ram #(.WIDTH(LW), .DEPTH(NUM_BUCKETS)) u_heads (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  chs_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_links (
    .clk_i, .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .raddr_i(link_raddr), .rdata_o(link_rdata)
  );

  chs_ram #(.WIDTH(KeyW), .DEPTH(POOL_ENTRIES)) u_keys (
    .clk_i, .we_i(keys_we), .waddr_i(free_head_q[PAW-1:0]), .wdata_i(key_q),
    .raddr_i(link_raddr), .rdata_o(keys_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign sweep_last = (sweep_q == SW'(SWEEP - 1));
  assign div_last   = (div_cnt_q == DCW'(KeyW - 1));
  assign match      = (keys_rdata == key_q);

  // One restoring-division step a cycle; the quotient bit also feeds a
  // running remainder modulo NUM_BUCKETS, which stays below twice the count.
  assign div_eff = (divisor_q == '0) ? DivW'(1) : divisor_q;
  assign trial   = {rem_q, shift_q[KeyW-1]};
  assign qbit    = (trial >= {1'b0, div_eff});
  assign mod_t   = {bucket_q, qbit};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_SWEEP: begin
        if (sweep_last) begin
          state_d = (mode_q == MODE_CLEAR) ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (mode_i == MODE_CLEAR) begin
            state_d = S_SWEEP;
          end else if (key_i == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_last) begin
          state_d = (mode_q == MODE_ADD) ? S_ADD_RD : S_HEAD_RD;
        end
      end
      S_ADD_RD: begin
        state_d = (free_head_q >= LinkNone) ? S_DONE : S_ADD_WR;
      end
      S_ADD_WR:  state_d = S_DONE;
      S_HEAD_RD: state_d = S_HEAD_LD;
      S_HEAD_LD: state_d = S_NODE_RD;
      S_NODE_RD: begin
        state_d = (cur_q >= LinkNone) ? S_DONE : S_NODE_CHK;
      end
      S_NODE_CHK: begin
        if (mode_q == MODE_LOOKUP) begin
          state_d = match ? S_DONE : S_NODE_RD;
        end else if (match && (prev_q < LinkNone)) begin
          state_d = S_FIX;
        end else begin
          state_d = S_NODE_RD;
        end
      end
      S_FIX: state_d = S_NODE_RD;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    shift_d     = shift_q;
    rem_d       = rem_q;
    bucket_d    = bucket_q;
    div_cnt_d   = div_cnt_q;
    sweep_d     = sweep_q;
    free_head_d = free_head_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    count_d     = count_q;
    found_d     = found_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;

    head_we    = 1'b0;
    head_waddr = bucket_q;
    head_wdata = link_rdata;
    head_raddr = bucket_q;
    link_we    = 1'b0;
    link_waddr = cur_q[PAW-1:0];
    link_wdata = free_head_q;
    link_raddr = cur_q[PAW-1:0];
    keys_we    = 1'b0;

    unique case (state_q)
      S_SWEEP: begin
        head_we    = (32'(sweep_q) < NUM_BUCKETS);
        head_waddr = BW'(sweep_q);
        head_wdata = LinkNone;
        link_we    = (32'(sweep_q) < POOL_ENTRIES);
        link_waddr = PAW'(sweep_q);
        link_wdata = LW'(sweep_q) + LW'(1);
        sweep_d    = sweep_q + SW'(1);
        if (sweep_last) begin
          sweep_d     = '0;
          free_head_d = '0;
          count_d     = '0;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          found_d   = 1'b0;
          status_d  = (mode_i != MODE_CLEAR && key_i == '0) ? STATUS_ZERO : STATUS_OK;
          shift_d   = key_i;
          rem_d     = '0;
          bucket_d  = '0;
          div_cnt_d = '0;
          sweep_d   = '0;
        end
      end
      S_DIV: begin
        rem_d     = qbit ? DivW'(trial - {1'b0, div_eff}) : trial[DivW-1:0];
        shift_d   = {shift_q[KeyW-2:0], 1'b0};
        bucket_d  = (mod_t >= (BW+1)'(NUM_BUCKETS)) ?
                    BW'(mod_t - (BW+1)'(NUM_BUCKETS)) : mod_t[BW-1:0];
        div_cnt_d = div_cnt_q + DCW'(1);
      end
      S_ADD_RD: begin
        link_raddr = free_head_q[PAW-1:0];
        if (free_head_q >= LinkNone) begin
          status_d = STATUS_FULL;
        end
      end
      S_ADD_WR: begin
        // Push the free head onto the bucket chain.
        link_we     = 1'b1;
        link_waddr  = free_head_q[PAW-1:0];
        link_wdata  = head_rdata;
        head_we     = 1'b1;
        head_wdata  = free_head_q;
        keys_we     = 1'b1;
        free_head_d = link_rdata;
        count_d     = count_q + CW'(1);
      end
      S_HEAD_RD: ;
      S_HEAD_LD: begin
        cur_d  = head_rdata;
        prev_d = LinkNone;
      end
      S_NODE_RD: ;
      S_NODE_CHK: begin
        cur_d = link_rdata;
        if (match) begin
          found_d = 1'b1;
        end
        if (mode_q == MODE_DELETE) begin
          if (match) begin
            // Unlink and free; a predecessor link is patched in S_FIX.
            link_we     = 1'b1;
            free_head_d = cur_q;
            if (count_q != '0) begin
              count_d = count_q - CW'(1);
            end
            if (prev_q >= LinkNone) begin
              head_we = 1'b1;
            end
          end else begin
            prev_d = cur_q;
          end
        end
      end
      S_FIX: begin
        link_we    = 1'b1;
        link_waddr = prev_q[PAW-1:0];
        link_wdata = cur_q;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      mode_q      <= MODE_ADD;
      divisor_q   <= DivW'(1);
      sweep_q     <= '0;
      div_cnt_q   <= '0;
      free_head_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      div_cnt_q   <= div_cnt_d;
      free_head_q <= free_head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        mode_q <= mode_i;
      end
      if (key_divisor_we_i) begin
        divisor_q <= key_divisor_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_q <= key_i;
    end
    shift_q  <= shift_d;
    rem_q    <= rem_d;
    bucket_q <= bucket_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    found_q  <= found_d;
    status_q <= status_d;
    if (state_q == S_DONE && out_free) begin
      res_found_q  <= found_q;
      res_status_q <= status_q;
      res_count_q  <= count_q[CountOutW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = res_found_q;
  assign status_o      = res_status_q;
  assign entry_count_o = res_count_q;

  // The free-list head is always a pool node or the end-of-chain value.
  a_free_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= LinkNone)
    else $error("free list head out of range");

  // The entry count never exceeds the pool.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(POOL_ENTRIES))
    else $error("entry count exceeds pool size");

  // A successful add stores exactly one more entry.
  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ADD_WR |=> count_q == $past(count_q) + CW'(1))
    else $error("add did not bump the entry count");

  // The sweep leaves an empty table with the free list starting at node zero.
  a_sweep_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && sweep_last) |=> (free_head_q == '0 && count_q == '0))
    else $error("sweep did not reset the free list");

endmodule

`default_nettype wire

[sim/tb_chained_hash_set.sv]
// Self-checking testbench for chained_hash_set: a driver, a monitor and a
// predictor of the chained set and its node pool. Depends on chs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_chained_hash_set;
  import chs_pkg::*;

  localparam int Buckets = 64;
  localparam int Pool    = 128;
  localparam int NoLink  = Pool;
  localparam int WatchdogLimit = 40000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
  } set_op_t;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
    logic [7:0] count;
  } set_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic div_we = 1'b0;
  logic [31:0] div_data = 32'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = MODE_ADD;
  logic [63:0] in_key = 64'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic found;
  logic [1:0] status;
  logic [7:0] entry_count;

  chained_hash_set DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .key_divisor_we_i(div_we), .key_divisor_i(div_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(in_mode), .key_i(in_key),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .found_o(found), .status_o(status), .entry_count_o(entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Operations waiting to be driven, and results waiting to come back.
  set_op_t     pending_ops[$];
  set_result_t expected_results[$];
  int          error_count = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;

  // Predictor copy of the table. Links use the value Pool as "no node".
  logic [31:0] divisor_shadow = 32'd1;
  int          heads[Buckets];
  logic [63:0] node_key[Pool];
  int          node_next[Pool];
  int          free_node;
  int          stored;

  function automatic void relink_table();
    for (int i = 0; i < Buckets; i++) heads[i] = NoLink;
    for (int i = 0; i < Pool; i++) node_next[i] = i + 1;
    free_node = 0;
    stored = 0;
  endfunction

  // Applies one operation to the predictor state and returns its result.
  function automatic set_result_t apply_set_op(set_op_t op);
    set_result_t r;
    logic [63:0] d;
    int b, n, prev, nxt, steps;
    r.found = 1'b0;
    r.status = STATUS_OK;
    d = (divisor_shadow == 0) ? 64'd1 : {32'd0, divisor_shadow};
    b = int'((op.key / d) % Buckets);
    if (op.mode == MODE_CLEAR) begin
      relink_table();
    end else if (op.key == 64'd0) begin
      r.status = STATUS_ZERO;
    end else if (op.mode == MODE_ADD) begin
      if (free_node >= Pool) begin
        r.status = STATUS_FULL;
      end else begin
        n = free_node;
        free_node = node_next[n];
        node_next[n] = heads[b];
        heads[b] = n;
        node_key[n] = op.key;
        stored++;
      end
    end else if (op.mode == MODE_DELETE) begin
      // Every matching node goes back to the free list, not just the first.
      prev = NoLink;
      n = heads[b];
      steps = 0;
      while (n < Pool && steps < Pool) begin
        nxt = node_next[n];
        steps++;
        if (node_key[n] == op.key) begin
          if (prev < Pool) node_next[prev] = nxt;
          else heads[b] = nxt;
          node_next[n] = free_node;
          free_node = n;
          if (stored > 0) stored--;
          r.found = 1'b1;
        end else begin
          prev = n;
        end
        n = nxt;
      end
    end else begin
      n = heads[b];
      steps = 0;
      while (n < Pool && steps < Pool) begin
        if (node_key[n] == op.key) begin
          r.found = 1'b1;
          break;
        end
        n = node_next[n];
        steps++;
      end
    end
    r.count = stored[7:0];
    return r;
  endfunction

  // Driver: on a transfer the operation is predicted, then the next one is
  // presented unless the sender is idling this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_results.push_back(apply_set_op('{in_mode, in_key}));
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        set_op_t op;
        op = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_mode <= op.mode;
        in_key <= op.key;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          error_count++;
        end else begin
          set_result_t e;
          e = expected_results.pop_front();
          if (found !== e.found) begin
            $error("found: expected %0d, actual %0d", e.found, found);
            error_count++;
          end
          if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            error_count++;
          end
          if (entry_count !== e.count) begin
            $error("entry_count: expected %0d, actual %0d", e.count, entry_count);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: a long stretch without any transfer means the block hung.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Recently added keys, reused so that deletes and lookups hit.
  logic [63:0] recent_keys[$];

  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55 && recent_keys.size() > 0)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    else if (r < 80)
      return 64'($urandom_range(1, 2048));
    else
      return {$urandom(), $urandom()};
  endfunction

  function automatic set_op_t random_op(int add_pct);
    set_op_t op;
    int r;
    r = $urandom_range(0, 99);
    op.key = pick_key();
    if (r < add_pct) begin
      op.mode = MODE_ADD;
      recent_keys.push_back(op.key);
      if (recent_keys.size() > 24) void'(recent_keys.pop_front());
    end else if (r < add_pct + (100 - add_pct) * 4 / 10) begin
      op.mode = MODE_DELETE;
    end else if (r < 95) begin
      op.mode = MODE_LOOKUP;
    end else if (r < 98) begin
      op.mode = 2'($urandom_range(0, 2));
      op.key = 64'd0;
    end else begin
      op.mode = MODE_CLEAR;
      if ($urandom_range(0, 1) == 0) op.key = 64'd0;
    end
    return op;
  endfunction

  task automatic drain();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_divisor(logic [31:0] value);
    @(posedge clk);
    div_we <= 1'b1;
    div_data <= value;
    @(posedge clk);
    div_we <= 1'b0;
    divisor_shadow = value;
  endtask

  task automatic run_phase(logic [31:0] div, int s_idle, int r_stall, int add_pct, int n);
    drain();
    write_divisor(div);
    sender_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    for (int i = 0; i < n; i++) pending_ops.push_back(random_op(add_pct));
  endtask

  initial begin
    relink_table();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: key extremes, duplicates, zero keys, clears and a
    // delete of a node in the middle of a chain.
    pending_ops.push_back('{MODE_ADD, 64'hFFFF_FFFF_FFFF_FFFF});
    pending_ops.push_back('{MODE_ADD, 64'd1});
    pending_ops.push_back('{MODE_ADD, 64'd1});
    pending_ops.push_back('{MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF});
    pending_ops.push_back('{MODE_LOOKUP, 64'd1});
    pending_ops.push_back('{MODE_DELETE, 64'd1});
    pending_ops.push_back('{MODE_LOOKUP, 64'd1});
    pending_ops.push_back('{MODE_DELETE, 64'd1});
    pending_ops.push_back('{MODE_ADD, 64'd0});
    pending_ops.push_back('{MODE_DELETE, 64'd0});
    pending_ops.push_back('{MODE_LOOKUP, 64'd0});
    pending_ops.push_back('{MODE_ADD, 64'd64});
    pending_ops.push_back('{MODE_ADD, 64'd128});
    pending_ops.push_back('{MODE_ADD, 64'd192});
    pending_ops.push_back('{MODE_DELETE, 64'd128});
    pending_ops.push_back('{MODE_LOOKUP, 64'd64});
    pending_ops.push_back('{MODE_LOOKUP, 64'd192});
    pending_ops.push_back('{MODE_LOOKUP, 64'd128});
    pending_ops.push_back('{MODE_CLEAR, 64'd0});
    pending_ops.push_back('{MODE_LOOKUP, 64'd64});
    pending_ops.push_back('{MODE_ADD, 64'h8000_0000_0000_0000});
    pending_ops.push_back('{MODE_CLEAR, 64'h1234_5678_9ABC_DEF0});

    // Random part across divisor settings and handshake pressure. The
    // add-heavy phases run the pool into the full state.
    run_phase(32'd1,          0,  0,  45, 280);
    run_phase(32'd0,          78, 0,  45, 270);
    run_phase(32'hFFFF_FFFF,  0,  78, 45, 270);
    run_phase(32'd8,          12, 12, 80, 290);
    run_phase($urandom(),     0,  0,  50, 270);
    run_phase(32'd64,         12, 12, 65, 270);
    drain();
    repeat (600) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
